// ----- hw/rtl/fspa_pkg.sv -----
// shared types and constants for the fenced staging pool allocator
package fspa_pkg;
   localparam int MaxBlocks = 16;
   localparam int IdxW = $clog2(MaxBlocks);
   localparam int CntW = $clog2(MaxBlocks + 1);
   localparam logic [31:0] LimitBytes = 32'h8000_0000;

   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_SIGNAL  = 2'd1,
      OP_BEGIN   = 2'd2,
      OP_RELEASE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_PLACED  = 2'd0,
      ST_CREATED = 2'd1,
      ST_NONE    = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_APPEND,
      S_DONE
   } state_type;

   localparam logic [0:0] RegMinBlock = 1'd0;
   localparam logic [0:0] RegMargin   = 1'd1;

   typedef struct packed {
      logic load;
      logic step;
      logic append;
      logic finish;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic walk_end;
      logic hit;
      logic reject;
      logic full;
   } stat_type;

   function automatic logic [31:0] pow2_ceil(input logic [31:0] s);
      logic [31:0] v;
      v = s - 32'd1;
      v = v | (v >> 1);
      v = v | (v >> 2);
      v = v | (v >> 4);
      v = v | (v >> 8);
      v = v | (v >> 16);
      return v + 32'd1;
   endfunction
endpackage

// ----- hw/rtl/fspa_datapath.sv -----
// block table, fences and per-entry walk for the staging allocator
module fspa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  fspa_pkg::cmd_type    cmd,
   output fspa_pkg::stat_type   stat,
   input  logic [1:0]           opcode,
   input  logic [31:0]          request_bytes,
   input  logic [47:0]          fence_value,
   input  logic [31:0]          min_block_bytes,
   input  logic [47:0]          idle_fence_margin,
   output logic [1:0]           status,
   output logic [3:0]           block_index,
   output logic [30:0]          block_offset,
   output logic [31:0]          block_capacity,
   output logic [4:0]           blocks_live
);
   import fspa_pkg::*;

   logic [31:0] cap_ff [MaxBlocks];
   logic [31:0] used_ff [MaxBlocks];
   logic [47:0] fence_ff [MaxBlocks];
   logic [MaxBlocks-1:0] pend_ff, pend_in;
   logic [CntW-1:0] live_ff, live_in, rd_ff, rd_in, wr_ff, wr_in;
   logic [47:0] sub_ff, sub_in, done_ff, done_in;
   logic [1:0] op_ff;
   logic [31:0] req_ff;
   logic [1:0] st_ff;
   logic [IdxW-1:0] idx_ff;
   logic [30:0] off_ff;
   logic [31:0] capo_ff;
   logic [IdxW-1:0] ri, wi;
   logic [31:0] rc, ru, msat, sz, newcap;
   logic [47:0] rf;
   logic [48:0] fsum;
   logic rp, fits, idle, hit_now;

   assign ri = rd_ff[IdxW-1:0];
   assign wi = wr_ff[IdxW-1:0];
   assign rc = cap_ff[ri];
   assign ru = used_ff[ri];
   assign rf = fence_ff[ri];
   assign rp = pend_ff[ri];
   assign fits = (rc >= ru) && ((rc - ru) >= req_ff);
   assign fsum = {1'b0, rf} + {1'b0, idle_fence_margin};
   assign idle = !rp && (fsum < {1'b0, done_ff});
   assign hit_now = (op_ff == OP_RESERVE) && fits;
   assign msat = (min_block_bytes > LimitBytes) ? LimitBytes : min_block_bytes;
   assign sz = (req_ff > msat) ? req_ff : msat;
   assign newcap = pow2_ceil(sz);

   assign stat.walk_end = (rd_ff >= live_ff);
   assign stat.hit = hit_now;
   assign stat.reject = (req_ff == 32'd0) || (req_ff > LimitBytes);
   assign stat.full = (live_ff == CntW'(MaxBlocks));

   always_comb begin
      pend_in = pend_ff;
      live_in = live_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      sub_in = sub_ff;
      done_in = done_ff;
      if (cmd.load) begin
         rd_in = '0;
         wr_in = '0;
         if (opcode == OP_SIGNAL) sub_in = fence_value;
         if (opcode == OP_BEGIN) done_in = fence_value;
      end else if (cmd.step) begin
         rd_in = rd_ff + CntW'(1);
         unique case (op_ff)
            OP_RESERVE: if (fits) pend_in[ri] = 1'b1;
            OP_SIGNAL:  pend_in[ri] = 1'b0;
            OP_BEGIN:   ;
            OP_RELEASE: if (!idle) begin
               pend_in[wi] = rp;
               wr_in = wr_ff + CntW'(1);
            end
            default: ;
         endcase
      end else if (cmd.append) begin
         pend_in[live_ff[IdxW-1:0]] = 1'b1;
         live_in = live_ff + CntW'(1);
      end else if (cmd.finish && op_ff == OP_RELEASE) begin
         for (int k = 0; k < MaxBlocks; k++)
            if (CntW'(k) >= wr_ff) pend_in[k] = 1'b0;
         live_in = wr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         live_ff <= '0;
         rd_ff <= '0;
         wr_ff <= '0;
         sub_ff <= '0;
         done_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         live_ff <= live_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         sub_ff <= sub_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= opcode;
         req_ff <= request_bytes;
         idx_ff <= '0;
         off_ff <= '0;
         capo_ff <= '0;
      end else if (cmd.step) begin
         unique case (op_ff)
            OP_RESERVE: if (fits) begin
               used_ff[ri] <= ru + req_ff;
               idx_ff <= ri;
               off_ff <= ru[30:0];
               capo_ff <= rc;
            end
            OP_SIGNAL: if (rp) fence_ff[ri] <= sub_ff;
            OP_BEGIN: if (!rp && (rf == 48'd0 || rf <= done_ff)) used_ff[ri] <= '0;
            OP_RELEASE: if (!idle) begin
               cap_ff[wi] <= rc;
               used_ff[wi] <= ru;
               fence_ff[wi] <= rf;
            end
            default: ;
         endcase
      end else if (cmd.append) begin
         cap_ff[live_ff[IdxW-1:0]] <= newcap;
         used_ff[live_ff[IdxW-1:0]] <= req_ff;
         fence_ff[live_ff[IdxW-1:0]] <= sub_ff;
         idx_ff <= live_ff[IdxW-1:0];
         off_ff <= '0;
         capo_ff <= newcap;
      end
      if (cmd.finish) st_ff <= cmd.status;
   end

   assign status = st_ff;
   assign block_index = 4'(idx_ff);
   assign block_offset = (st_ff == ST_PLACED || st_ff == ST_CREATED) ? off_ff : '0;
   assign block_capacity = (st_ff == ST_PLACED || st_ff == ST_CREATED) ? capo_ff : '0;
   assign blocks_live = 5'(live_ff);
endmodule

// ----- hw/rtl/fspa_control.sv -----
// sequencer for the staging allocator table walk
module fspa_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         opcode,
   input  fspa_pkg::stat_type stat,
   output fspa_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               done
);
   import fspa_pkg::*;

   state_type state_ff, state_in;
   logic res_ff, res_in;

   always_comb begin
      state_in = state_ff;
      res_in = res_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            state_in = S_WALK;
            res_in = (opcode == OP_RESERVE);
         end
         S_WALK: priority if (res_ff && stat.reject) state_in = S_DONE;
            else if (stat.walk_end) state_in = (res_ff && !stat.full) ? S_APPEND : S_DONE;
            else if (stat.hit) state_in = S_DONE;
            else state_in = S_WALK;
         S_APPEND: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = ST_NONE;
      unique case (state_ff)
         S_IDLE: cmd.load = start;
         S_WALK: priority if (res_ff && stat.reject) begin
               cmd.finish = 1'b1;
            end else if (stat.walk_end) begin
               cmd.finish = !(res_ff && !stat.full);
               cmd.status = res_ff ? ST_FULL : ST_NONE;
            end else begin
               cmd.step = 1'b1;
               if (stat.hit) begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_PLACED;
               end
            end
         S_APPEND: begin
            cmd.append = 1'b1;
            cmd.finish = 1'b1;
            cmd.status = ST_CREATED;
         end
         S_DONE: ;
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         res_ff <= res_in;
      end
   end
endmodule

// ----- hw/rtl/fenced_staging_pool_allocator.sv -----
// top level of the fenced staging pool allocator
// one command at a time: start while busy is low; the result shows for one cycle with
// rsp_valid, and the receiver must take it then. A command keeps busy high while the walk
// steps through the live blocks (the walk touches one table entry per cycle), and through
// the append state when a new block is appended; a reserve that fits stops at the first
// fitting block, and a rejected reserve ends without any walk step.
module fenced_staging_pool_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_request_bytes,
   input  logic [47:0] req_fence_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_block_index,
   output logic [30:0] rsp_block_offset,
   output logic [31:0] rsp_block_capacity,
   output logic [4:0]  rsp_blocks_live,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import fspa_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [31:0] min_ff;
   logic [47:0] margin_ff;
   logic go;

   assign go = start && !busy;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 32'd65536;
         margin_ff <= 48'd3;
      end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
         if (paddr[3] == RegMinBlock) min_ff <= pwdata[31:0];
         else margin_ff <= pwdata[47:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2:0] == 3'd0) begin
         if (paddr[3] == RegMinBlock) prdata = {32'd0, min_ff};
         else if (paddr[3] == RegMargin) prdata = {16'd0, margin_ff};
      end
   end

   fspa_control u_ctrl (
      .clock(clock), .reset(reset), .start(go), .opcode(req_opcode),
      .stat(stat), .cmd(cmd), .busy(busy), .done(rsp_valid)
   );

   fspa_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .opcode(req_opcode), .request_bytes(req_request_bytes),
      .fence_value(req_fence_value), .min_block_bytes(min_ff),
      .idle_fence_margin(margin_ff), .status(rsp_status),
      .block_index(rsp_block_index), .block_offset(rsp_block_offset),
      .block_capacity(rsp_block_capacity), .blocks_live(rsp_blocks_live)
   );
endmodule

// ----- hw/rtl/fspa_checker.sv -----
// port-level checks for the staging allocator
module fspa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [4:0] rsp_blocks_live,
   input logic [31:0] rsp_block_capacity
);
   import fspa_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("no busy after accept");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside command");
   a_live_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_blocks_live <= 5'(MaxBlocks))) else $error("live count too big");
   a_none_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NONE || rsp_status == ST_FULL)) |->
      (rsp_block_capacity == 32'd0))
      else $error("capacity on empty result");
endmodule

bind fenced_staging_pool_allocator fspa_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_blocks_live(rsp_blocks_live),
   .rsp_block_capacity(rsp_block_capacity)
);
